// ===== rtl/core/krt_pkg.sv =====
// Package for the keyed record table: request and result codes, the record
// type held by each table cell, and elaboration helpers for the OR tree.
// No dependencies.
package krt_pkg;

  localparam int unsigned KEY_W       = 32;
  localparam int unsigned QTY_W       = 32;
  localparam int unsigned PRICE_W     = 48;
  localparam int unsigned IN_PRICE_W  = 47;
  localparam int unsigned DELTA_W     = 32;
  localparam int unsigned SLOT_W      = 7;
  // Whole dollars times 100 needs 39 signed bits.
  localparam int unsigned DPRICE_W    = 39;
  localparam int          DollarCents = 100;
  localparam int unsigned TreeFanin   = 16;
  localparam int unsigned REC_W       = QTY_W + PRICE_W;

  typedef enum logic [1:0] {
    MODE_INSERT    = 2'd0,
    MODE_SEARCH    = 2'd1,
    MODE_ADD_QTY   = 2'd2,
    MODE_ADD_PRICE = 2'd3
  } krt_mode_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_DUPLICATE = 2'd2,
    STATUS_FULL      = 2'd3
  } krt_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_TREE,
    S_APPLY
  } krt_state_e;

  typedef struct packed {
    logic signed [KEY_W-1:0]   part_key;
    logic signed [QTY_W-1:0]   quantity;
    logic signed [PRICE_W-1:0] price_cents;
  } krt_rec_t;

  // Number of nodes on a given level of the reduction tree (level 0 = leaves).
  function automatic int unsigned level_nodes(int unsigned n, int unsigned lvl);
    int unsigned c;
    c = n;
    for (int unsigned i = 0; i < 8; i++) begin
      if (i < lvl) begin
        c = (c + TreeFanin - 1) / TreeFanin;
      end
    end
    return c;
  endfunction

  // Registered levels needed to reduce n leaves to one root.
  function automatic int unsigned tree_levels(int unsigned n);
    int unsigned c;
    int unsigned l;
    c = n;
    l = 0;
    for (int unsigned i = 0; i < 8; i++) begin
      if (c > 1) begin
        c = (c + TreeFanin - 1) / TreeFanin;
        l++;
      end
    end
    return (l == 0) ? 1 : l;
  endfunction

endpackage

// ===== rtl/core/krt_if.sv =====
// Valid/ready channel interfaces for requests and results of the keyed
// record table. Depends on krt_pkg.
interface krt_req_if import krt_pkg::*; ();
  logic                         valid;
  logic                         ready;
  krt_mode_e                    mode;
  logic signed [KEY_W-1:0]      part_key;
  logic signed [QTY_W-1:0]      new_quantity;
  logic        [IN_PRICE_W-1:0] new_price_cents;
  logic signed [DELTA_W-1:0]    delta;

  modport source (output valid, mode, part_key, new_quantity, new_price_cents, delta,
                  input ready);
  modport sink   (input valid, mode, part_key, new_quantity, new_price_cents, delta,
                  output ready);
endinterface

interface krt_rsp_if import krt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  krt_status_e               status;
  logic [SLOT_W-1:0]         slot;
  logic signed [QTY_W-1:0]   quantity_out;
  logic signed [PRICE_W-1:0] price_out_cents;

  modport source (output valid, status, slot, quantity_out, price_out_cents,
                  input ready);
  modport sink   (input valid, status, slot, quantity_out, price_out_cents,
                  output ready);
endinterface

// ===== rtl/core/krt_cell.sv =====
// One table cell: holds a single record, compares it with the request key
// and registers its record, gated by the hit, toward the OR tree.
// Depends on krt_pkg.
module krt_cell import krt_pkg::*; #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned IDX_W = 7,
  parameter int unsigned CNT_W = 8
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  krt_rec_t                 wr_rec_i,
  input  logic signed [KEY_W-1:0]  key_i,
  input  logic [CNT_W-1:0]         count_i,
  output logic [IDX_W+REC_W:0]     leaf_o
);

  krt_rec_t                rec_q;
  logic                    hit;
  logic [IDX_W+REC_W:0]    leaf_d;
  logic [IDX_W+REC_W:0]    leaf_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      rec_q <= wr_rec_i;
    end
  end

  // Only cells below the fill count hold a written record.
  assign hit    = (count_i > CNT_W'(IDX)) && (rec_q.part_key == key_i);
  assign leaf_d = hit ? {1'b1, IDX_W'(IDX), rec_q.quantity, rec_q.price_cents} : '0;

  always_ff @(posedge clk_i) begin
    leaf_q <= leaf_d;
  end

  assign leaf_o = leaf_q;

endmodule

// ===== rtl/core/krt_or_tree.sv =====
// Registered OR reduction of the cell outputs. Keys are unique, so at most
// one leaf is nonzero and the root carries the matching record.
// Depends on krt_pkg.
module krt_or_tree import krt_pkg::*; #(
  parameter int unsigned N = 128,
  parameter int unsigned W = 88
) (
  input  logic         clk_i,
  input  logic [W-1:0] leaf_i [N],
  output logic [W-1:0] root_o
);

  localparam int unsigned LEVELS = tree_levels(N);

  wire [W-1:0] lvl_w [LEVELS][N];

  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    localparam int unsigned NODES = level_nodes(N, l);
    localparam int unsigned PREV  = level_nodes(N, l - 1);
    for (genvar j = 0; j < NODES; j++) begin : g_node
      logic [W-1:0] child [TreeFanin];
      logic [W-1:0] or_d;
      logic [W-1:0] node_q;

      for (genvar k = 0; k < TreeFanin; k++) begin : g_child
        if (j * TreeFanin + k < PREV) begin : g_used
          if (l == 1) begin : g_leaf
            assign child[k] = leaf_i[j * TreeFanin + k];
          end else begin : g_inner
            assign child[k] = lvl_w[l-2][j * TreeFanin + k];
          end
        end else begin : g_pad
          assign child[k] = '0;
        end
      end

      always_comb begin
        or_d = '0;
        for (int k = 0; k < TreeFanin; k++) begin
          or_d = or_d | child[k];
        end
      end

      always_ff @(posedge clk_i) begin
        node_q <= or_d;
      end

      assign lvl_w[l-1][j] = node_q;
    end
  end

  assign root_o = lvl_w[LEVELS-1][0];

endmodule

// ===== rtl/core/keyed_record_table.sv =====
// Keyed record table: a row of cells, one record each, matched in parallel.
// A request passes the request registers, the registered cell outputs, the L levels of
// the registered OR tree that gathers the match, L = ceil(log16(TABLE_DEPTH)), and the
// output register. One request is in flight at a time; a finished result may wait in the
// output register while the next request is taken. Reset clears the fill count
// and control state; record contents are unspecified until written.
module keyed_record_table import krt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  krt_req_if.sink   req_i,
  krt_rsp_if.source rsp_o
);

  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LEAF_W = 1 + IDX_W + REC_W;
  localparam int unsigned LEVELS = tree_levels(TABLE_DEPTH);
  localparam int unsigned TCNT_W = $clog2(LEVELS + 1);

  localparam logic signed [QTY_W-1:0]   QtyMax   = {1'b0, {(QTY_W-1){1'b1}}};
  localparam logic signed [QTY_W-1:0]   QtyMin   = {1'b1, {(QTY_W-1){1'b0}}};
  localparam logic signed [PRICE_W-1:0] PriceMax = {1'b0, {(PRICE_W-1){1'b1}}};
  localparam logic signed [PRICE_W-1:0] PriceMin = {1'b1, {(PRICE_W-1){1'b0}}};

  krt_state_e state_q, state_d;

  krt_mode_e                    req_mode_q;
  logic signed [KEY_W-1:0]      req_key_q;
  logic signed [QTY_W-1:0]      req_qty_q;
  logic        [IN_PRICE_W-1:0] req_price_q;
  logic signed [DELTA_W-1:0]    req_delta_q;
  logic signed [DPRICE_W-1:0]   dprice_q;
  logic [TCNT_W-1:0]            tree_cnt_q;
  logic [CNT_W-1:0]             count_q;

  logic                         rsp_valid_q;
  krt_status_e                  rsp_status_q;
  logic [SLOT_W-1:0]            rsp_slot_q;
  logic signed [QTY_W-1:0]      rsp_qty_q;
  logic signed [PRICE_W-1:0]    rsp_price_q;

  logic [LEAF_W-1:0]            leaf [TABLE_DEPTH];
  logic [LEAF_W-1:0]            root;
  logic                         found;
  logic [IDX_W-1:0]             root_idx;
  logic signed [QTY_W-1:0]      root_qty;
  logic signed [PRICE_W-1:0]    root_price;

  logic                         accept;
  logic                         apply_fire;
  logic                         wr_go;
  logic [IDX_W-1:0]             wr_idx;
  krt_rec_t                     wr_rec;
  logic [TABLE_DEPTH-1:0]       wr_en;
  logic                         count_inc;
  krt_status_e                  res_status;
  logic [IDX_W-1:0]             res_idx;
  logic signed [QTY_W-1:0]      res_qty;
  logic signed [PRICE_W-1:0]    res_price;
  logic signed [QTY_W:0]        qty_sum;
  logic signed [PRICE_W:0]      price_sum;
  logic signed [QTY_W-1:0]      qty_sat;
  logic signed [PRICE_W-1:0]    price_sat;

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign apply_fire  = (state_q == S_APPLY) && (!rsp_valid_q || rsp_o.ready);

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_mode_q  <= req_i.mode;
      req_key_q   <= req_i.part_key;
      req_qty_q   <= req_i.new_quantity;
      req_price_q <= req_i.new_price_cents;
      req_delta_q <= req_i.delta;
    end
    if (state_q == S_MATCH) begin
      dprice_q <= DPRICE_W'(req_delta_q) * DPRICE_W'(DollarCents);
    end
  end

  // Row of cells.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign wr_en[i] = wr_go && (wr_idx == IDX_W'(i));
    krt_cell #(
      .IDX   (i),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i    (clk_i),
      .wr_en_i  (wr_en[i]),
      .wr_rec_i (wr_rec),
      .key_i    (req_key_q),
      .count_i  (count_q),
      .leaf_o   (leaf[i])
    );
  end

  krt_or_tree #(
    .N (TABLE_DEPTH),
    .W (LEAF_W)
  ) u_or_tree (
    .clk_i  (clk_i),
    .leaf_i (leaf),
    .root_o (root)
  );

  assign found      = root[LEAF_W-1];
  assign root_idx   = root[REC_W +: IDX_W];
  assign root_qty   = root[PRICE_W +: QTY_W];
  assign root_price = root[PRICE_W-1:0];

  // Saturating sums for the two add requests.
  assign qty_sum   = {root_qty[QTY_W-1], root_qty} + {req_delta_q[DELTA_W-1], req_delta_q};
  assign price_sum = {root_price[PRICE_W-1], root_price} + (PRICE_W+1)'(dprice_q);
  assign qty_sat   = (qty_sum[QTY_W] != qty_sum[QTY_W-1])
                   ? (qty_sum[QTY_W] ? QtyMin : QtyMax) : qty_sum[QTY_W-1:0];
  assign price_sat = (price_sum[PRICE_W] != price_sum[PRICE_W-1])
                   ? (price_sum[PRICE_W] ? PriceMin : PriceMax) : price_sum[PRICE_W-1:0];

  always_comb begin
    res_status = STATUS_OK;
    res_idx    = root_idx;
    res_qty    = root_qty;
    res_price  = root_price;
    wr_go      = 1'b0;
    count_inc  = 1'b0;
    if (req_mode_q == MODE_INSERT) begin
      if (count_q == CNT_W'(TABLE_DEPTH)) begin
        res_status = STATUS_FULL;
        res_idx    = '0;
        res_qty    = '0;
        res_price  = '0;
      end else if (found) begin
        res_status = STATUS_DUPLICATE;
      end else begin
        res_idx   = IDX_W'(count_q);
        res_qty   = req_qty_q;
        res_price = PRICE_W'(req_price_q);
        wr_go     = apply_fire;
        count_inc = apply_fire;
      end
    end else if (!found) begin
      res_status = STATUS_NOT_FOUND;
      res_idx    = '0;
      res_qty    = '0;
      res_price  = '0;
    end else begin
      case (req_mode_q)
        MODE_ADD_QTY: begin
          res_qty = qty_sat;
          wr_go   = apply_fire;
        end
        MODE_ADD_PRICE: begin
          res_price = price_sat;
          wr_go     = apply_fire;
        end
        default: begin
        end
      endcase
    end
  end

  assign wr_idx             = res_idx;
  assign wr_rec.part_key    = req_key_q;
  assign wr_rec.quantity    = res_qty;
  assign wr_rec.price_cents = res_price;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_MATCH;
      S_MATCH: state_d = S_TREE;
      S_TREE:  if (tree_cnt_q == TCNT_W'(LEVELS - 1)) state_d = S_APPLY;
      S_APPLY: if (apply_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      tree_cnt_q <= '0;
      count_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_TREE) begin
        tree_cnt_q <= tree_cnt_q + TCNT_W'(1);
      end else begin
        tree_cnt_q <= '0;
      end
      if (count_inc) begin
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (apply_fire) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply_fire) begin
      rsp_status_q <= res_status;
      rsp_slot_q   <= SLOT_W'(res_idx);
      rsp_qty_q    <= res_qty;
      rsp_price_q  <= res_price;
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.status          = rsp_status_q;
  assign rsp_o.slot            = rsp_slot_q;
  assign rsp_o.quantity_out    = rsp_qty_q;
  assign rsp_o.price_out_cents = rsp_price_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("fill count exceeds table depth");

  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(wr_en))
    else $error("more than one cell written in a cycle");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apply_fire && req_mode_q == MODE_INSERT && res_status == STATUS_OK
    |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("successful insert did not advance the fill count");

  a_write_only_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_go |-> state_q == S_APPLY && apply_fire)
    else $error("cell write outside the result transfer");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_MATCH && !req_i.ready)
    else $error("accepted request did not start a match");

endmodule

// ===== tb/sv/tb_keyed_record_table.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for keyed_record_table: directed and random requests over the
// valid/ready channels, checked against a record-table predictor held in a scoreboard class.
// Depends on krt_pkg, krt_req_if, krt_rsp_if and keyed_record_table.
module tb_keyed_record_table import krt_pkg::*; ();

  localparam int unsigned TABLE_DEPTH = 128;
  localparam int          CLK_PERIOD  = 8;
  localparam int          LATENCY     = 5;
  localparam longint      QTY_HI      = 64'sd2147483647;
  localparam longint      QTY_LO      = -64'sd2147483648;
  localparam longint      PRICE_HI    = 64'sd140737488355327;
  localparam longint      PRICE_LO    = -64'sd140737488355328;

  localparam logic signed [31:0] KEY_TOP    = 32'sh7fff_ffff;
  localparam logic signed [31:0] KEY_BOTTOM = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_ZERO   = 32'sh0000_0000;
  localparam logic signed [31:0] KEY_ONES   = 32'shffff_ffff;
  localparam logic signed [31:0] KEY_ABSENT = 32'sh0000_3039;
  localparam logic signed [31:0] WORD_MAX   = 32'sh7fff_ffff;
  localparam logic signed [31:0] WORD_MIN   = 32'sh8000_0000;
  localparam logic [IN_PRICE_W-1:0] PRICE_IN_MAX = '1;

  typedef struct {
    krt_mode_e                    mode;
    logic signed [KEY_W-1:0]      part_key;
    logic signed [QTY_W-1:0]      new_quantity;
    logic        [IN_PRICE_W-1:0] new_price_cents;
    logic signed [DELTA_W-1:0]    delta;
  } part_request_t;

  typedef struct {
    krt_status_e               status;
    logic [SLOT_W-1:0]         slot;
    logic signed [QTY_W-1:0]   quantity;
    logic signed [PRICE_W-1:0] price_cents;
  } table_reply_t;

  class record_table_model;
    logic signed [KEY_W-1:0]   keys       [TABLE_DEPTH];
    logic signed [QTY_W-1:0]   quantities [TABLE_DEPTH];
    logic signed [PRICE_W-1:0] prices     [TABLE_DEPTH];
    int unsigned               fill;
    table_reply_t              expected_replies[$];
    int unsigned               failures;

    // Applies one accepted request to the shadow table and queues the reply it must give.
    function void note_request(part_request_t r);
      table_reply_t rep;
      int           hit;
      longint       total;
      hit = -1;
      for (int i = 0; i < int'(fill); i++) begin
        if (hit < 0 && keys[i] == r.part_key) hit = i;
      end
      rep.status      = STATUS_OK;
      rep.slot        = '0;
      rep.quantity    = '0;
      rep.price_cents = '0;
      // A full table refuses every insert before the key is even considered.
      if (r.mode == MODE_INSERT && fill == TABLE_DEPTH) begin
        rep.status = STATUS_FULL;
      end else if (r.mode == MODE_INSERT && hit >= 0) begin
        rep.status = STATUS_DUPLICATE;
      end else if (r.mode == MODE_INSERT) begin
        hit             = fill;
        keys[hit]       = r.part_key;
        quantities[hit] = r.new_quantity;
        prices[hit]     = {1'b0, r.new_price_cents};
        fill++;
      end else if (hit < 0) begin
        rep.status = STATUS_NOT_FOUND;
      end else if (r.mode == MODE_ADD_QTY) begin
        total = longint'(quantities[hit]) + longint'(r.delta);
        if (total > QTY_HI) total = QTY_HI;
        if (total < QTY_LO) total = QTY_LO;
        quantities[hit] = total[QTY_W-1:0];
      end else if (r.mode == MODE_ADD_PRICE) begin
        total = longint'(prices[hit]) + longint'(r.delta) * DollarCents;
        if (total > PRICE_HI) total = PRICE_HI;
        if (total < PRICE_LO) total = PRICE_LO;
        prices[hit] = total[PRICE_W-1:0];
      end
      if (rep.status != STATUS_FULL && rep.status != STATUS_NOT_FOUND) begin
        rep.slot        = hit[SLOT_W-1:0];
        rep.quantity    = quantities[hit];
        rep.price_cents = prices[hit];
      end
      expected_replies.push_back(rep);
    endfunction

    function void check_result(krt_status_e status, logic [SLOT_W-1:0] slot,
                               logic signed [QTY_W-1:0] quantity,
                               logic signed [PRICE_W-1:0] price_cents);
      table_reply_t want;
      if (expected_replies.size() == 0) begin
        $error("unexpected result: status %s slot %0d", status.name(), slot);
        failures++;
      end else begin
        want = expected_replies.pop_front();
        if (status !== want.status) begin
          $error("status: expected %s actual %s", want.status.name(), status.name());
          failures++;
        end
        if (slot !== want.slot) begin
          $error("slot: expected %0d actual %0d", want.slot, slot);
          failures++;
        end
        if (quantity !== want.quantity) begin
          $error("quantity_out: expected %0d actual %0d", want.quantity, quantity);
          failures++;
        end
        if (price_cents !== want.price_cents) begin
          $error("price_out_cents: expected %0d actual %0d", want.price_cents, price_cents);
          failures++;
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic signed [KEY_W-1:0] key_pool[$];
  record_table_model ledger = new();

  krt_req_if req_if ();
  krt_rsp_if rsp_if ();

  keyed_record_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  initial begin
    #(5_000_000);
    $display("tb_keyed_record_table: FAIL");
    $finish;
  end

  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      ledger.check_result(rsp_if.status, rsp_if.slot, rsp_if.quantity_out,
                          rsp_if.price_out_cents);
    end
  end

  // Holds the request until its transfer, with random gaps in front of it.
  task automatic issue(input part_request_t r);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid           <= 1'b1;
    req_if.mode            <= r.mode;
    req_if.part_key        <= r.part_key;
    req_if.new_quantity    <= r.new_quantity;
    req_if.new_price_cents <= r.new_price_cents;
    req_if.delta           <= r.delta;
    do @(posedge clk_i); while (!req_if.ready);
    ledger.note_request(r);
  endtask

  task automatic issue_fields(input krt_mode_e mode, input logic signed [31:0] part_key,
                              input logic signed [31:0] quantity,
                              input logic [IN_PRICE_W-1:0] price_cents,
                              input logic signed [31:0] delta);
    part_request_t r;
    r.mode            = mode;
    r.part_key        = part_key;
    r.new_quantity    = quantity;
    r.new_price_cents = price_cents;
    r.delta           = delta;
    issue(r);
  endtask

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return 32'(int'($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_request();
    part_request_t r;
    logic [63:0]   wide;
    int unsigned   insert_pct;
    int unsigned   reuse_pct;
    insert_pct = (ledger.fill < TABLE_DEPTH) ? 35 : 15;
    if ($urandom_range(0, 99) < insert_pct) r.mode = MODE_INSERT;
    else r.mode = krt_mode_e'($urandom_range(1, 3));
    // Inserts bring fresh keys half the time; the other requests mostly name known ones.
    reuse_pct = (r.mode == MODE_INSERT) ? 50 : 80;
    if ($urandom_range(0, 99) < reuse_pct) begin
      r.part_key = key_pool[$urandom_range(0, key_pool.size() - 1)];
    end else begin
      r.part_key = $urandom;
      key_pool.push_back(r.part_key);
    end
    r.new_quantity = pick_word();
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0:       r.new_price_cents = '0;
      1:       r.new_price_cents = PRICE_IN_MAX;
      default: r.new_price_cents = wide[IN_PRICE_W-1:0];
    endcase
    r.delta = pick_word();
    issue(r);
  endtask

  initial begin
    rst_ni                 = 1'b0;
    req_if.valid           = 1'b0;
    req_if.mode            = MODE_INSERT;
    req_if.part_key        = '0;
    req_if.new_quantity    = '0;
    req_if.new_price_cents = '0;
    req_if.delta           = '0;
    rsp_if.ready           = 1'b0;
    send_idle_pct          = 26;
    recv_idle_pct          = 59;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty table, then the field extremes, duplicates and saturation at both ends.
    issue_fields(MODE_SEARCH,    KEY_ZERO,   0, 0, 0);
    issue_fields(MODE_ADD_QTY,   KEY_ZERO,   0, 0, 1);
    issue_fields(MODE_ADD_PRICE, KEY_ZERO,   0, 0, 1);
    issue_fields(MODE_INSERT,    KEY_TOP,    WORD_MAX, PRICE_IN_MAX, 0);
    issue_fields(MODE_INSERT,    KEY_BOTTOM, WORD_MIN, 0, 0);
    issue_fields(MODE_INSERT,    KEY_ZERO,   0, 0, WORD_MIN);
    issue_fields(MODE_INSERT,    KEY_ONES,   -1, 1, WORD_MAX);
    issue_fields(MODE_INSERT,    KEY_TOP,    0, 0, 0);
    issue_fields(MODE_SEARCH,    KEY_BOTTOM, WORD_MAX, PRICE_IN_MAX, WORD_MAX);
    issue_fields(MODE_SEARCH,    KEY_ABSENT, 0, 0, 0);
    issue_fields(MODE_ADD_QTY,   KEY_TOP,    0, 0, 1);
    issue_fields(MODE_ADD_QTY,   KEY_TOP,    0, 0, WORD_MAX);
    issue_fields(MODE_ADD_QTY,   KEY_BOTTOM, 0, 0, -1);
    issue_fields(MODE_ADD_QTY,   KEY_BOTTOM, 0, 0, WORD_MIN);
    issue_fields(MODE_ADD_QTY,   KEY_BOTTOM, 0, 0, WORD_MAX);
    issue_fields(MODE_ADD_PRICE, KEY_TOP,    0, 0, 1);
    issue_fields(MODE_ADD_PRICE, KEY_TOP,    0, 0, WORD_MAX);
    issue_fields(MODE_ADD_PRICE, KEY_ONES,   0, 0, WORD_MIN);
    issue_fields(MODE_ADD_PRICE, KEY_ZERO,   0, 0, 0);
    issue_fields(MODE_ADD_QTY,   KEY_ZERO,   0, 0, 0);
    issue_fields(MODE_ADD_PRICE, KEY_ABSENT, 0, 0, WORD_MAX);
    key_pool.push_back(KEY_TOP);
    key_pool.push_back(KEY_BOTTOM);
    key_pool.push_back(KEY_ZERO);
    key_pool.push_back(KEY_ONES);
    key_pool.push_back(KEY_ABSENT);

    repeat (450) random_request();
    send_idle_pct = 59;
    recv_idle_pct = 26;
    repeat (450) random_request();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (375) random_request();

    // Large withdrawals in whole dollars drive one price down to the negative limit.
    repeat (700) begin
      issue_fields(MODE_ADD_PRICE, KEY_BOTTOM, 0, 0, {1'b1, 31'($urandom_range(0, 1000))});
    end
    repeat (5) issue_fields(MODE_ADD_PRICE, KEY_BOTTOM, 0, 0, pick_word());

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (ledger.expected_replies.size() != 0) @(posedge clk_i);
    repeat (4 * LATENCY) @(posedge clk_i);
    if (ledger.failures == 0 && ledger.expected_replies.size() == 0) begin
      $display("tb_keyed_record_table: PASS");
    end else begin
      $display("tb_keyed_record_table: FAIL");
    end
    $finish;
  end

endmodule
